>>> sv/mfs_pkg.sv
// ----------------------------------------------------------------------------
// Matrix factorization SGD engine package
// Shared item types, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mfs_pkg;

    // Feature counters travel in a field that covers up to 64 features.
    localparam int FEAT_W    = 6;
    localparam int FRAC_BITS = 24;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TRAIN   = 2'd1;
    localparam logic [1:0] CMD_PREDICT = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [1:0] CFG_LEARN_RATE     = 2'd0;
    localparam logic [1:0] CFG_REGULARIZATION = 2'd1;
    localparam logic [1:0] CFG_BASELINE_MEAN  = 2'd2;

    localparam logic [23:0]        LEARN_RATE_RST     = 24'd16777;
    localparam logic [23:0]        REGULARIZATION_RST = 24'd419430;
    localparam logic signed [31:0] BASELINE_MEAN_RST  = 32'sd0;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [18:0]        user_index;
        logic [14:0]        movie_index;
        logic [2:0]         rating_value;
        logic [3:0]         feature_index;
        logic               load_to_movie;
        logic signed [31:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] predicted_rating;
        logic               saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZERO,
        OP_RD,
        OP_MUL,
        OP_ACC,
        OP_DEND,
        OP_ERR,
        OP_T1,
        OP_UWR,
        OP_MWR,
        OP_PUSH
    } t_dp_op;

    typedef enum logic [2:0] {
        SEL_DOT,
        SEL_ERR,
        SEL_UM,
        SEL_RU,
        SEL_UN,
        SEL_RM
    } t_mul_sel;

    typedef struct packed {
        t_dp_op              op;
        t_mul_sel            sel;
        logic [FEAT_W-1:0]   feat;
        logic                first;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic is_train;
        logic is_pred;
        logic load_ok;
        logic tp_ok;
        logic mul_done;
        logic out_full;
    } t_dp_status;

endpackage

>>> sv/matrix_factor_sgd_engine.sv
// ----------------------------------------------------------------------------
// Matrix factorization SGD engine
// Top level: user and movie feature tables trained by stochastic gradient
// descent, with load, train and predict commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) takes one command per
//   transaction. Loads write one feature word and give no result. Train and
//   predict give one result on the output channel (o_out_valid/i_out_ready,
//   o_out_item); for train it is the prediction before the update.
//   Configuration writes use i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data and are taken in any cycle; write them only while idle.
//   Timing: one item is processed at a time. All arithmetic shares a single
//   multiplier that works over ND = ceil((max(W,28)+2)/17) 17-bit digits per
//   product (ND = 2 at W = 32).
//   Reset restores the configuration registers and clears control state;
//   table contents are not cleared and must be loaded before use.
//   A stalled receiver holds the result in the output register; the next item
//   is still accepted and runs until its own result needs that register.
// ----------------------------------------------------------------------------
module matrix_factor_sgd_engine #(
    parameter int USER_COUNT    = 524288,
    parameter int MOVIE_COUNT   = 32768,
    parameter int FEATURE_COUNT = 10,
    parameter int WORD_BITS     = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mfs_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mfs_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import mfs_pkg::*;

    logic       in_acc;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign in_acc      = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    mfs_ctrl #(
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (in_acc),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mfs_datapath #(
        .USER_COUNT    (USER_COUNT),
        .MOVIE_COUNT   (MOVIE_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT),
        .WORD_BITS     (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (in_acc),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> sv/mfs_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Signed multiply over 17-bit digits of one operand, rounded to 24 fraction
// bits with halves away from zero, then saturated to the word range.
// ----------------------------------------------------------------------------
module mfs_mul #(
    parameter int OPW       = 34,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [OPW-1:0]       i_a,
    input  logic signed [OPW-1:0]       i_b,
    output logic                        o_busy,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_result,
    output logic                        o_clip
);
    import mfs_pkg::*;

    localparam int DIG = 17;
    localparam int ND  = (OPW + DIG - 1) / DIG;
    localparam int BW  = ND * DIG;
    localparam int PW  = 2 * OPW;
    localparam int CW  = $clog2(ND + 1);
    localparam int LW  = PW - FRAC_BITS + 1;

    logic                        r_busy, r_fin, r_done, r_neg, r_clip;
    logic [CW-1:0]               r_cnt;
    logic [OPW-1:0]              r_a;
    logic [BW-1:0]               r_b;
    logic [PW-1:0]               r_p;
    logic signed [WORD_BITS-1:0] r_res;

    logic [OPW-1:0]       mag_a, mag_b;
    logic [PW-1:0]        n_p;
    logic [PW:0]          rnd;
    logic [LW-1:0]        mag, lim;
    logic                 clip;
    logic [WORD_BITS-1:0] mag_w;

    assign mag_a = i_a[OPW-1] ? OPW'(~i_a + 1'b1) : OPW'(i_a);
    assign mag_b = i_b[OPW-1] ? OPW'(~i_b + 1'b1) : OPW'(i_b);

    // Most significant digit first, so the partial sum only ever grows.
    assign n_p = (r_p << DIG) + PW'(r_a * r_b[BW-1 -: DIG]);

    assign rnd   = {1'b0, r_p} + (PW + 1)'(1 << (FRAC_BITS - 1));
    assign mag   = rnd[PW:FRAC_BITS];
    assign lim   = (LW'(1) << (WORD_BITS - 1)) - LW'(!r_neg);
    assign clip  = mag > lim;
    assign mag_w = clip ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy && !r_fin) begin
                if (r_cnt == CW'(ND - 1)) begin
                    r_fin <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (r_fin) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= mag_a;
            r_b   <= BW'(mag_b);
            r_p   <= '0;
            r_neg <= i_a[OPW-1] ^ i_b[OPW-1];
        end else if (r_busy && !r_fin) begin
            r_p <= n_p;
            r_b <= r_b << DIG;
        end else if (r_fin) begin
            r_res  <= r_neg ? $signed(WORD_BITS'(0) - mag_w) : $signed(mag_w);
            r_clip <= clip;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;
    assign o_clip   = r_clip;

endmodule

>>> sv/mfs_datapath.sv
// ----------------------------------------------------------------------------
// Matrix factorization datapath
// Feature tables, configuration registers, dot accumulator, update adders,
// the shared multiplier and the output register.
// ----------------------------------------------------------------------------
module mfs_datapath #(
    parameter int USER_COUNT    = 524288,
    parameter int MOVIE_COUNT   = 32768,
    parameter int FEATURE_COUNT = 10,
    parameter int WORD_BITS     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_acc,
    input  mfs_pkg::t_in_item    i_in_item,
    input  mfs_pkg::t_dp_cmd     i_cmd,
    output mfs_pkg::t_dp_status  o_status,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mfs_pkg::t_out_item   o_out_item
);
    import mfs_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int OPW  = ((W > 28) ? W : 28) + 2;
    localparam int AW   = W + $clog2(FEATURE_COUNT + 1) + 1;
    localparam int PRW  = ((W > 32) ? W : 32) + 1;
    localparam int XW1  = (AW > PRW) ? AW : PRW;
    localparam int XW   = ((XW1 > W + 2) ? XW1 : W + 2) + 1;
    localparam int UD   = USER_COUNT * FEATURE_COUNT;
    localparam int MD   = MOVIE_COUNT * FEATURE_COUNT;
    localparam int UAW  = (UD > 1) ? $clog2(UD) : 1;
    localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;

    function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] v,
                                                   input int bits);
        logic signed [XW-1:0] hi, lo;
        hi = (XW'(1) <<< (bits - 1)) - XW'(1);
        lo = -hi - XW'(1);
        if (v > hi) begin
            clamp = hi;
        end else if (v < lo) begin
            clamp = lo;
        end else begin
            clamp = v;
        end
    endfunction

    function automatic logic clips(input logic signed [XW-1:0] v, input int bits);
        logic signed [XW-1:0] hi, lo;
        hi = (XW'(1) <<< (bits - 1)) - XW'(1);
        lo = -hi - XW'(1);
        clips = (v > hi) || (v < lo);
    endfunction

    logic [W-1:0] r_user_mem  [UD];
    logic [W-1:0] r_movie_mem [MD];

    t_in_item           r_item;
    logic [23:0]        r_lr, r_reg;
    logic signed [31:0] r_base;
    logic signed [W-1:0] r_urd, r_mrd, r_dot, r_err, r_t1, r_un;
    logic signed [AW-1:0] r_acc;
    logic signed [31:0] r_pred;
    logic               r_clip, n_clip;
    logic               r_out_valid;
    t_out_item          r_out;

    logic                 mul_start, mul_busy, mul_done, mul_clip;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [W-1:0]  mul_res;

    logic [UAW-1:0] ld_uaddr, uaddr;
    logic [MAW-1:0] ld_maddr, maddr;
    logic signed [W-1:0]  load_w, dot_w, un_w, mn_w;
    logic signed [XW-1:0] acc_x, pred_x, diff_x, upd_u, upd_m;
    logic                 acc_clip, pred_clip, un_clip, mn_clip;

    assign ld_uaddr = UAW'(int'(r_item.feature_index) * USER_COUNT + int'(r_item.user_index));
    assign ld_maddr = MAW'(int'(r_item.feature_index) * MOVIE_COUNT
                           + int'(r_item.movie_index));
    assign uaddr    = UAW'(int'(i_cmd.feat) * USER_COUNT + int'(r_item.user_index));
    assign maddr    = MAW'(int'(i_cmd.feat) * MOVIE_COUNT + int'(r_item.movie_index));

    assign load_w    = W'(clamp(XW'(r_item.load_value), W));
    assign acc_x     = XW'(r_acc);
    assign dot_w     = W'(clamp(acc_x, W));
    assign acc_clip  = clips(acc_x, W);
    assign pred_x    = XW'(r_base) + XW'(dot_w);
    assign pred_clip = clips(pred_x, 32);
    assign diff_x    = XW'($signed({1'b0, r_item.rating_value, FRAC_BITS'(0)})) - XW'(r_dot);
    assign upd_u     = XW'(r_urd) + XW'(r_t1) - XW'(mul_res);
    assign upd_m     = XW'(r_mrd) + XW'(r_t1) - XW'(mul_res);
    assign un_w      = W'(clamp(upd_u, W));
    assign mn_w      = W'(clamp(upd_m, W));
    assign un_clip   = clips(upd_u, W);
    assign mn_clip   = clips(upd_m, W);

    always_comb begin
        mul_a = OPW'(r_urd);
        mul_b = OPW'(r_mrd);
        case (i_cmd.sel)
            SEL_DOT: begin
                mul_a = OPW'(r_urd);
                mul_b = OPW'(r_mrd);
            end
            SEL_ERR: begin
                mul_a = OPW'($signed({1'b0, r_lr}));
                mul_b = OPW'(diff_x);
            end
            SEL_UM: begin
                mul_a = OPW'(r_err);
                mul_b = OPW'(r_mrd);
            end
            SEL_RU: begin
                mul_a = OPW'($signed({1'b0, r_reg}));
                mul_b = OPW'(r_urd);
            end
            SEL_UN: begin
                mul_a = OPW'(r_err);
                mul_b = OPW'(r_un);
            end
            SEL_RM: begin
                mul_a = OPW'($signed({1'b0, r_reg}));
                mul_b = OPW'(r_mrd);
            end
            default: begin
                mul_a = OPW'(r_urd);
                mul_b = OPW'(r_mrd);
            end
        endcase
    end

    assign mul_start = (i_cmd.op == OP_MUL);

    mfs_mul #(
        .OPW       (OPW),
        .WORD_BITS (W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_busy   (mul_busy),
        .o_done   (mul_done),
        .o_result (mul_res),
        .o_clip   (mul_clip)
    );

    always_comb begin
        n_clip = r_clip;
        case (i_cmd.op)
            OP_ZERO: n_clip = 1'b0;
            OP_DEND: n_clip = r_clip | acc_clip | (i_cmd.first & pred_clip);
            OP_UWR:  n_clip = r_clip | un_clip;
            OP_MWR:  n_clip = r_clip | mn_clip;
            default: n_clip = r_clip;
        endcase
        if (mul_done) begin
            n_clip = n_clip | mul_clip;
        end
        if (i_in_acc) begin
            n_clip = 1'b0;
        end
    end

    // Control and configuration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_lr        <= LEARN_RATE_RST;
            r_reg       <= REGULARIZATION_RST;
            r_base      <= BASELINE_MEAN_RST;
        end else begin
            r_clip <= n_clip;
            if (i_cmd.op == OP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LEARN_RATE:     r_lr   <= i_cfg_data[23:0];
                    CFG_REGULARIZATION: r_reg  <= i_cfg_data[23:0];
                    CFG_BASELINE_MEAN:  r_base <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_item <= i_in_item;
        end
        case (i_cmd.op)
            OP_ZERO: r_pred <= 32'sd0;
            OP_ACC:  r_acc  <= r_acc + AW'(mul_res);
            OP_DEND: begin
                r_dot <= dot_w;
                r_acc <= '0;
                if (i_cmd.first) begin
                    r_pred <= 32'(clamp(pred_x, 32));
                end
            end
            OP_ERR:  r_err <= mul_res;
            OP_T1:   r_t1  <= mul_res;
            OP_UWR:  r_un  <= un_w;
            OP_PUSH: begin
                r_out.predicted_rating <= r_pred;
                r_out.saturated        <= r_clip;
            end
            default: ;
        endcase
        if (i_in_acc) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && !r_item.load_to_movie) begin
            r_user_mem[ld_uaddr] <= load_w;
        end else if (i_cmd.op == OP_UWR) begin
            r_user_mem[uaddr] <= un_w;
        end
        if (i_cmd.op == OP_RD) begin
            r_urd <= $signed(r_user_mem[uaddr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && r_item.load_to_movie) begin
            r_movie_mem[ld_maddr] <= load_w;
        end else if (i_cmd.op == OP_MWR) begin
            r_movie_mem[maddr] <= mn_w;
        end
        if (i_cmd.op == OP_RD) begin
            r_mrd <= $signed(r_movie_mem[maddr]);
        end
    end

    always_comb begin
        o_status.is_load  = (r_item.cmd == CMD_LOAD);
        o_status.is_train = (r_item.cmd == CMD_TRAIN);
        o_status.is_pred  = (r_item.cmd == CMD_PREDICT);
        o_status.load_ok  = (int'(r_item.feature_index) < FEATURE_COUNT)
                            && (r_item.load_to_movie
                                ? (int'(r_item.movie_index) < MOVIE_COUNT)
                                : (int'(r_item.user_index) < USER_COUNT));
        o_status.tp_ok    = (int'(r_item.user_index) < USER_COUNT)
                            && (int'(r_item.movie_index) < MOVIE_COUNT);
        o_status.mul_done = mul_done;
        o_status.out_full = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_mul_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MUL) |-> !mul_busy)
        else $error("multiplier started while busy");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUSH) |-> !r_out_valid)
        else $error("result pushed over a pending result");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |=> !mul_done)
        else $error("multiplier done held for more than one cycle");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_acc |-> (i_cmd.op == OP_NONE || i_cmd.op == OP_LOAD || i_cmd.op == OP_PUSH))
        else $error("item accepted while datapath work is pending");

endmodule

>>> sv/mfs_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix factorization controller
// Sequences load, predict and train over the datapath, one item at a time.
// ----------------------------------------------------------------------------
module mfs_ctrl #(
    parameter int FEATURE_COUNT = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_acc,
    output logic                 o_in_ready,
    input  mfs_pkg::t_dp_status  i_status,
    output mfs_pkg::t_dp_cmd     o_cmd
);
    import mfs_pkg::*;

    localparam int KW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DRD, S_DMUL, S_DWAIT, S_DACC, S_DEND,
        S_EMUL, S_EWAIT, S_ETAKE, S_URD, S_UMMUL, S_UMWAIT, S_T1A,
        S_RUMUL, S_RUWAIT, S_UWR, S_UNMUL, S_UNWAIT, S_T1B, S_RMMUL,
        S_RMWAIT, S_MWR, S_OUT
    } t_state;

    t_state        r_state;
    t_dp_cmd       r_cmd;
    logic [KW-1:0] r_f, r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.op    <= OP_NONE;
            r_cmd.sel   <= SEL_DOT;
            r_cmd.feat  <= '0;
            r_cmd.first <= 1'b0;
            r_f         <= '0;
            r_k         <= '0;
        end else begin
            r_cmd.op <= OP_NONE;
            case (r_state)
                S_IDLE: begin
                    if (i_in_acc) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (i_status.is_load) begin
                        if (i_status.load_ok) begin
                            r_cmd.op <= OP_LOAD;
                        end
                        r_state <= S_IDLE;
                    end else if (i_status.is_train || i_status.is_pred) begin
                        if (i_status.tp_ok) begin
                            r_f        <= '0;
                            r_k        <= '0;
                            r_cmd.op   <= OP_RD;
                            r_cmd.feat <= '0;
                            r_state    <= S_DRD;
                        end else begin
                            r_cmd.op <= OP_ZERO;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DRD: begin
                    r_cmd.op  <= OP_MUL;
                    r_cmd.sel <= SEL_DOT;
                    r_state   <= S_DMUL;
                end
                S_DMUL: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op <= OP_ACC;
                        r_state  <= S_DACC;
                    end
                end
                S_DACC: begin
                    if (r_f == KW'(FEATURE_COUNT - 1)) begin
                        r_cmd.op    <= OP_DEND;
                        r_cmd.first <= (r_k == '0);
                        r_state     <= S_DEND;
                    end else begin
                        r_f        <= r_f + 1'b1;
                        r_cmd.op   <= OP_RD;
                        r_cmd.feat <= FEAT_W'(r_f + 1'b1);
                        r_state    <= S_DRD;
                    end
                end
                S_DEND: begin
                    if (i_status.is_pred) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cmd.op  <= OP_MUL;
                        r_cmd.sel <= SEL_ERR;
                        r_state   <= S_EMUL;
                    end
                end
                S_EMUL: r_state <= S_EWAIT;
                S_EWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op <= OP_ERR;
                        r_state  <= S_ETAKE;
                    end
                end
                S_ETAKE: begin
                    r_cmd.op   <= OP_RD;
                    r_cmd.feat <= FEAT_W'(r_k);
                    r_state    <= S_URD;
                end
                S_URD: begin
                    r_cmd.op  <= OP_MUL;
                    r_cmd.sel <= SEL_UM;
                    r_state   <= S_UMMUL;
                end
                S_UMMUL: r_state <= S_UMWAIT;
                S_UMWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op <= OP_T1;
                        r_state  <= S_T1A;
                    end
                end
                S_T1A: begin
                    r_cmd.op  <= OP_MUL;
                    r_cmd.sel <= SEL_RU;
                    r_state   <= S_RUMUL;
                end
                S_RUMUL: r_state <= S_RUWAIT;
                S_RUWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op   <= OP_UWR;
                        r_cmd.feat <= FEAT_W'(r_k);
                        r_state    <= S_UWR;
                    end
                end
                S_UWR: begin
                    r_cmd.op  <= OP_MUL;
                    r_cmd.sel <= SEL_UN;
                    r_state   <= S_UNMUL;
                end
                S_UNMUL: r_state <= S_UNWAIT;
                S_UNWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op <= OP_T1;
                        r_state  <= S_T1B;
                    end
                end
                S_T1B: begin
                    r_cmd.op  <= OP_MUL;
                    r_cmd.sel <= SEL_RM;
                    r_state   <= S_RMMUL;
                end
                S_RMMUL: r_state <= S_RMWAIT;
                S_RMWAIT: begin
                    if (i_status.mul_done) begin
                        r_cmd.op   <= OP_MWR;
                        r_cmd.feat <= FEAT_W'(r_k);
                        r_state    <= S_MWR;
                    end
                end
                S_MWR: begin
                    if (r_k == KW'(FEATURE_COUNT - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        // Next feature: a fresh dot product over the updated rows.
                        r_k        <= r_k + 1'b1;
                        r_f        <= '0;
                        r_cmd.op   <= OP_RD;
                        r_cmd.feat <= '0;
                        r_state    <= S_DRD;
                    end
                end
                S_OUT: begin
                    if (!i_status.out_full) begin
                        r_cmd.op <= OP_PUSH;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = r_cmd;

endmodule
